FILE: design/ids_pkg.sv
// ----------------------------------------------------------------------------
// ids_pkg
// Shared constants and types of the isolated-diagonal square finder.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int MAX_COLS_DEF = 2048;
  localparam int CFG_W        = 12;
  localparam int OUT_W        = 12;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = CFG_W'(2048);

  typedef struct packed {
    logic pixel;
    logic last_col;
    logic eoi;
  } ids_item_t;

endpackage

FILE: design/ids_front.sv
// ----------------------------------------------------------------------------
// ids_front
// Input side: holds the row width, tracks the column of each pixel beat and
// tags the beats that close a row or the image.
// ----------------------------------------------------------------------------
module ids_front #(
  parameter  int MAX_COLS = ids_pkg::MAX_COLS_DEF,
  localparam int AW       = $clog2(MAX_COLS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ids_pkg::CFG_W-1:0] cfg_columns_in_use,
  input  logic                     in_push,
  input  logic                     in_pixel,
  input  logic                     in_end_of_image,
  input  logic                     q_full,
  output logic                     q_push,
  output logic [AW-1:0]            q_col,
  output ids_pkg::ids_item_t       q_item
);

  localparam int NW = $clog2(MAX_COLS + 1);
  localparam int WW = (NW > ids_pkg::CFG_W) ? NW : ids_pkg::CFG_W;

  logic [ids_pkg::CFG_W-1:0] width_cfg_r;
  logic [AW-1:0]             col_r;
  logic [AW-1:0]             col_nxt;
  logic [WW-1:0]             cfg_ext;
  logic [WW-1:0]             max_ext;
  logic [WW-1:0]             width;
  logic [WW-1:0]             col_ext;
  logic [WW-1:0]             cur_ext;
  logic                      last;

  always_comb begin
    cfg_ext = WW'(width_cfg_r);
    max_ext = WW'(MAX_COLS);
    priority if (cfg_ext == '0) begin
      width = WW'(1);
    end else if (cfg_ext > max_ext) begin
      width = max_ext;
    end else begin
      width = cfg_ext;
    end
    col_ext = WW'(col_r);
    cur_ext = (col_ext >= width) ? (width - WW'(1)) : col_ext;
    last    = ((cur_ext + WW'(1)) >= width) || in_end_of_image;
    col_nxt = last ? '0 : AW'(cur_ext + WW'(1));
  end

  assign q_push = in_push && !q_full;
  assign q_col  = cur_ext[AW-1:0];

  always_comb begin
    q_item          = '0;
    q_item.pixel    = in_pixel;
    q_item.last_col = last;
    q_item.eoi      = in_end_of_image;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= ids_pkg::COLUMNS_RESET;
      col_r       <= '0;
    end else begin
      if (cfg_we) begin
        width_cfg_r <= cfg_columns_in_use;
      end
      if (q_push) begin
        col_r <= col_nxt;
      end
    end
  end

endmodule

FILE: design/ids_queue.sv
// ----------------------------------------------------------------------------
// ids_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module ids_queue #(
  parameter  int DW    = 8,
  parameter  int DEPTH = ids_pkg::QUEUE_DEPTH,
  localparam int PW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  logic [DW-1:0] slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slot_r[rd_ptr_r];

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= advance(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= advance(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/ids_back.sv
// ----------------------------------------------------------------------------
// ids_back
// Back side: forward pass per pixel, reverse pass per row over the stored
// row, line memories, best side, result register and clearing sweep.
// ----------------------------------------------------------------------------
module ids_back #(
  parameter  int MAX_COLS = ids_pkg::MAX_COLS_DEF,
  localparam int AW       = $clog2(MAX_COLS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  logic [AW-1:0]             q_col,
  input  ids_pkg::ids_item_t        q_item,
  output logic                      q_pop,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [ids_pkg::OUT_W-1:0] out_longest_diagonal
);

  localparam int VW = $clog2(MAX_COLS + 1);
  localparam logic [VW-1:0] MAX_V     = VW'(MAX_COLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_COLS - 1);

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_FWD     = 3'd1;
  localparam logic [2:0] ST_REV     = 3'd2;
  localparam logic [2:0] ST_REV_END = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  function automatic logic [VW-1:0] sat_inc(input logic [VW-1:0] v);
    return (v >= MAX_V) ? MAX_V : v + VW'(1);
  endfunction

  function automatic logic [VW-1:0] min3(input logic [VW-1:0] a,
                                         input logic [VW-1:0] b,
                                         input logic [VW-1:0] c);
    logic [VW-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic          row_mem  [MAX_COLS];
  logic [VW-1:0] fwd_mem  [MAX_COLS];
  logic [VW-1:0] rev_mem  [MAX_COLS];
  logic [VW-1:0] vert_mem [MAX_COLS];

  logic          row_rd_r;
  logic [VW-1:0] fwd_rd_r;
  logic [VW-1:0] rev_rd_r;
  logic [VW-1:0] vert_rd_r;

  logic [2:0]               state_r;
  logic [2:0]               state_nxt;
  logic [AW-1:0]            clr_addr_r;
  logic                     b_vld_r;
  logic [AW-1:0]            b_col_r;
  ids_pkg::ids_item_t       b_item_r;
  logic                     r_vld_r;
  logic [AW-1:0]            r_col_r;
  logic [AW-1:0]            rev_addr_r;
  logic                     eoi_hold_r;
  logic [VW-1:0]            hz_run_r;
  logic [VW-1:0]            upleft_r;
  logic [VW-1:0]            run_r;
  logic [VW-1:0]            upright_r;
  logic [VW-1:0]            best_r;
  logic [VW-1:0]            best_nxt;
  logic                     out_vld_r;
  logic [ids_pkg::OUT_W-1:0] out_data_r;

  logic          is_clr;
  logic          row_done;
  logic          out_load;
  logic [AW-1:0] rd_addr;
  logic [VW-1:0] f_diag;
  logic [VW-1:0] f_hz;
  logic [VW-1:0] f_side;
  logic [VW-1:0] f_hz_new;
  logic [VW-1:0] r_side;
  logic [VW-1:0] r_run_new;
  logic [VW-1:0] r_vert_new;
  logic [VW-1:0] cand;

  assign is_clr   = (state_r == ST_CLEAR);
  assign row_done = b_vld_r && b_item_r.last_col;
  assign q_pop    = (state_r == ST_FWD) && !q_empty && !row_done;
  assign rd_addr  = (state_r == ST_REV) ? rev_addr_r : q_col;
  assign out_load = (state_r == ST_EMIT) && !out_vld_r;

  always_comb begin
    f_diag     = (b_col_r == '0) ? '0 : upleft_r;
    f_hz       = (b_col_r == '0) ? '0 : hz_run_r;
    f_side     = b_item_r.pixel ? sat_inc(min3(f_diag, f_hz, vert_rd_r)) : '0;
    f_hz_new   = b_item_r.pixel ? '0 : sat_inc(f_hz);
    r_side     = row_rd_r ? sat_inc(min3(upright_r, run_r, vert_rd_r)) : '0;
    r_run_new  = row_rd_r ? '0 : sat_inc(run_r);
    r_vert_new = row_rd_r ? '0 : sat_inc(vert_rd_r);
    priority if (b_vld_r) begin
      cand = f_side;
    end else if (r_vld_r) begin
      cand = r_side;
    end else begin
      cand = '0;
    end
    if (out_load) begin
      best_nxt = '0;
    end else begin
      best_nxt = (cand > best_r) ? cand : best_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = ST_FWD;
      end
      ST_FWD: begin
        if (row_done) state_nxt = ST_REV;
      end
      ST_REV: begin
        if (rev_addr_r == '0) state_nxt = ST_REV_END;
      end
      ST_REV_END: begin
        state_nxt = eoi_hold_r ? ST_EMIT : ST_FWD;
      end
      ST_EMIT: begin
        if (out_load) state_nxt = ST_CLEAR;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      b_vld_r    <= 1'b0;
      r_vld_r    <= 1'b0;
      eoi_hold_r <= 1'b0;
      best_r     <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= (is_clr && clr_addr_r != LAST_ADDR) ? clr_addr_r + AW'(1) : '0;
      b_vld_r    <= q_pop;
      r_vld_r    <= (state_r == ST_REV);
      if (row_done) begin
        eoi_hold_r <= b_item_r.eoi;
      end
      best_r <= best_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_col_r  <= q_col;
      b_item_r <= q_item;
    end
    if (b_vld_r) begin
      hz_run_r <= f_hz_new;
      upleft_r <= fwd_rd_r;
    end
    if (row_done) begin
      rev_addr_r <= b_col_r;
      run_r      <= '0;
      upright_r  <= '0;
    end else begin
      if (state_r == ST_REV) begin
        rev_addr_r <= rev_addr_r - AW'(1);
      end
      if (r_vld_r) begin
        run_r     <= r_run_new;
        upright_r <= rev_rd_r;
      end
    end
    r_col_r <= rev_addr_r;
    if (out_load) begin
      out_data_r <= ids_pkg::OUT_W'(best_r);
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r) begin
      row_mem[b_col_r] <= b_item_r.pixel;
    end
    row_rd_r <= row_mem[rev_addr_r];
  end

  always_ff @(posedge clk) begin
    if (is_clr) begin
      fwd_mem[clr_addr_r] <= '0;
    end else if (b_vld_r) begin
      fwd_mem[b_col_r] <= f_side;
    end
    fwd_rd_r <= fwd_mem[q_col];
  end

  always_ff @(posedge clk) begin
    if (is_clr) begin
      rev_mem[clr_addr_r] <= '0;
    end else if (r_vld_r) begin
      rev_mem[r_col_r] <= r_side;
    end
    rev_rd_r <= rev_mem[rev_addr_r];
  end

  always_ff @(posedge clk) begin
    if (is_clr) begin
      vert_mem[clr_addr_r] <= '0;
    end else if (r_vld_r) begin
      vert_mem[r_col_r] <= r_vert_new;
    end
    vert_rd_r <= vert_mem[rd_addr];
  end

  assign out_empty            = !out_vld_r;
  assign out_longest_diagonal = out_data_r;

  a_stages_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(b_vld_r && r_vld_r))
    else $error("forward and reverse stages active together");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    is_clr |-> (!b_vld_r && !r_vld_r && !q_pop))
    else $error("pass activity during clearing sweep");

  a_reverse_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (r_vld_r && $past(r_vld_r)) |-> ((r_col_r + AW'(1)) == $past(r_col_r)))
    else $error("reverse pass skipped a column");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_EMIT))
    else $error("result loaded outside of emit");

endmodule

FILE: design/isolated_diagonal_square_finder.sv
// ----------------------------------------------------------------------------
// isolated_diagonal_square_finder
// The result beat is loaded after the reverse pass over the last row, once the previous result is popped.
// Throughput: one pixel per cycle inside a row during the forward pass; each row adds a reverse pass
//   over the stored row on the line memories, during which pixels only fill the input queue.
// Reset (synchronous, active low) and every result start a clearing sweep over every address
//   of the line memories; pixels queue meanwhile.
// ----------------------------------------------------------------------------
module isolated_diagonal_square_finder #(
  parameter int MAX_COLS    = ids_pkg::MAX_COLS_DEF,
  parameter int QUEUE_DEPTH = ids_pkg::QUEUE_DEPTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [ids_pkg::CFG_W-1:0] cfg_columns_in_use,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic                      in_pixel,
  input  logic                      in_end_of_image,
  input  logic                      out_pop,
  output logic                      out_empty,
  output logic [ids_pkg::OUT_W-1:0] out_longest_diagonal
);

  localparam int AW     = $clog2(MAX_COLS);
  localparam int ITEM_W = $bits(ids_pkg::ids_item_t);
  localparam int DW     = AW + ITEM_W;

  logic               front_push;
  logic [AW-1:0]      front_col;
  ids_pkg::ids_item_t front_item;
  logic               queue_full;
  logic               queue_empty;
  logic               queue_pop;
  logic [DW-1:0]      queue_data;
  logic [AW-1:0]      back_col;
  ids_pkg::ids_item_t back_item;

  assign in_full   = queue_full;
  assign back_col  = queue_data[DW-1:ITEM_W];
  assign back_item = ids_pkg::ids_item_t'(queue_data[ITEM_W-1:0]);

  ids_front #(
    .MAX_COLS(MAX_COLS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_columns_in_use(cfg_columns_in_use),
    .in_push           (in_push),
    .in_pixel          (in_pixel),
    .in_end_of_image   (in_end_of_image),
    .q_full            (queue_full),
    .q_push            (front_push),
    .q_col             (front_col),
    .q_item            (front_item)
  );

  ids_queue #(
    .DW   (DW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (front_push),
    .push_data({front_col, front_item}),
    .full     (queue_full),
    .pop      (queue_pop),
    .pop_data (queue_data),
    .empty    (queue_empty)
  );

  ids_back #(
    .MAX_COLS(MAX_COLS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (queue_empty),
    .q_col               (back_col),
    .q_item              (back_item),
    .q_pop               (queue_pop),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_longest_diagonal(out_longest_diagonal)
  );

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the isolated-diagonal square finder: a table of
// directed beats, then random images over several row widths and idle mixes.
// Every accepted pixel updates a local model; each result beat is compared
// with the oldest pending square side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int LINE_DEPTH     = ids_pkg::MAX_COLS_DEF;
  localparam int SETTLE_CYCLES  = 3 * LINE_DEPTH + 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int PHASES         = 8;
  localparam int PHASE_BEATS    = 40;
  localparam int PHASE_IMAGES   = 5;
  localparam int DIRECTED_STEPS = 37;

  typedef logic [ids_pkg::OUT_W-1:0] side_t;
  localparam side_t SIDE_CAP = side_t'(LINE_DEPTH);

  typedef enum logic {STEP_PIXEL, STEP_WIDTH} step_kind_t;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    step_kind_t                kind;
    logic                      pixel;
    logic                      eoi;
    logic [ids_pkg::CFG_W-1:0] width;
    logic                      typed;
    side_t                     side;
  } step_t;

  logic                      clk;
  logic                      rst_n              = 1'b0;
  logic                      cfg_we             = 1'b0;
  logic [ids_pkg::CFG_W-1:0] cfg_columns_in_use = ids_pkg::COLUMNS_RESET;
  logic                      in_push            = 1'b0;
  logic                      in_full;
  logic                      in_pixel           = 1'b0;
  logic                      in_end_of_image    = 1'b0;
  logic                      out_pop            = 1'b0;
  logic                      out_empty;
  side_t                     out_longest_diagonal;

  isolated_diagonal_square_finder u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_columns_in_use   (cfg_columns_in_use),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_pixel             (in_pixel),
    .in_end_of_image      (in_end_of_image),
    .out_pop              (out_pop),
    .out_empty            (out_empty),
    .out_longest_diagonal (out_longest_diagonal)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  bit                        row_bits [LINE_DEPTH];
  side_t                     fwd_side [LINE_DEPTH];
  side_t                     rev_side [LINE_DEPTH];
  side_t                     vzero    [LINE_DEPTH];
  side_t                     hrun;
  side_t                     col_cnt;
  side_t                     best_side;
  side_t                     upleft_side;
  logic [ids_pkg::CFG_W-1:0] width_reg;

  side_t expected_sides [$];
  int    mismatches;
  int    beats_sent;
  int    images_sent;
  int    quiet_cycles;
  int    send_idle_pct;
  int    pop_stall_pct;
  step_t directed_steps [DIRECTED_STEPS];

  function automatic side_t bump(side_t v);
    return (v >= SIDE_CAP) ? SIDE_CAP : side_t'(v + 1'b1);
  endfunction

  function automatic side_t least3(side_t a, side_t b, side_t c);
    side_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic side_t effective_width(logic [ids_pkg::CFG_W-1:0] w);
    if (w == 0) return side_t'(1);
    if (w > SIDE_CAP) return SIDE_CAP;
    return w;
  endfunction

  function automatic void clear_image_state();
    for (int c = 0; c < LINE_DEPTH; c++) begin
      row_bits[c] = 1'b0;
      fwd_side[c] = '0;
      rev_side[c] = '0;
      vzero[c]    = '0;
    end
    hrun        = '0;
    col_cnt     = '0;
    best_side   = '0;
    upleft_side = '0;
  endfunction

  function automatic void sweep_right_to_left(side_t w);
    side_t run;
    side_t upright;
    side_t prev;
    side_t s;
    run     = '0;
    upright = '0;
    for (int c = int'(w) - 1; c >= 0; c--) begin
      prev = rev_side[c];
      if (row_bits[c]) begin
        s        = bump(least3(upright, run, vzero[c]));
        run      = '0;
        vzero[c] = '0;
      end else begin
        s        = '0;
        run      = bump(run);
        vzero[c] = bump(vzero[c]);
      end
      rev_side[c] = s;
      upright     = prev;
      if (s > best_side) best_side = s;
    end
  endfunction

  function automatic bit track_pixel(bit p, bit e, output side_t longest);
    side_t w;
    side_t c;
    side_t prev;
    side_t s;
    w = effective_width(width_reg);
    c = col_cnt;
    if (c >= w) c = side_t'(w - 1'b1);
    if (c == 0) begin
      hrun        = '0;
      upleft_side = '0;
    end
    prev        = fwd_side[c];
    row_bits[c] = p;
    if (p) begin
      s    = bump(least3(upleft_side, hrun, vzero[c]));
      hrun = '0;
    end else begin
      s    = '0;
      hrun = bump(hrun);
    end
    fwd_side[c] = s;
    upleft_side = prev;
    if (s > best_side) best_side = s;
    col_cnt = side_t'(c + 1'b1);
    if (col_cnt >= w || e) begin
      sweep_right_to_left(col_cnt);
      col_cnt     = '0;
      hrun        = '0;
      upleft_side = '0;
    end
    longest = best_side;
    if (e) begin
      clear_image_state();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(string what, side_t got, side_t want);
    mismatches++;
    $display("%0t mismatch: %s, longest_diagonal got %0d want %0d", $realtime, what, got, want);
  endtask

  task automatic send_beat(bit p, bit e, bit typed, side_t typed_side);
    side_t s;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push         <= 1'b1;
    in_pixel        <= p;
    in_end_of_image <= e;
    @(posedge clk);
    while (in_full) @(posedge clk);
    beats_sent++;
    if (track_pixel(p, e, s)) expected_sides.push_back(typed ? typed_side : s);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (expected_sides.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [ids_pkg::CFG_W-1:0] v);
    cfg_we             <= 1'b1;
    cfg_columns_in_use <= v;
    @(posedge clk);
    width_reg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic set_idle_mode(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct = 0;
        pop_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 45;
        pop_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        pop_stall_pct = 45;
      end
      default: begin
        send_idle_pct = 20;
        pop_stall_pct = 20;
      end
    endcase
  endtask

  task automatic send_image(bit partial);
    int  w;
    int  rows;
    int  tail;
    int  total;
    int  k;
    int  kmax;
    int  r0;
    int  c0;
    int  mode;
    int  r;
    int  col;
    bit  anti;
    bit  hit;
    bit  p;
    w = int'(effective_width(width_reg));
    if (w > 16) begin
      rows = 1;
      tail = $urandom_range(1, (w < 24) ? w : 24);
    end else begin
      rows = $urandom_range(1, (16 / w > 1) ? 16 / w : 1);
      tail = ($urandom_range(0, 9) < 7) ? w : $urandom_range(1, w);
    end
    total = (rows - 1) * w + tail;
    if (partial) begin
      if (total < 2) return;
      total = $urandom_range(1, total - 1);
    end
    kmax = (rows < w) ? rows : w;
    k    = $urandom_range(1, kmax);
    r0   = $urandom_range(0, rows - k);
    c0   = $urandom_range(0, w - k);
    mode = $urandom_range(0, 2);
    anti = $urandom_range(0, 1);
    for (int idx = 0; idx < total; idx++) begin
      r   = idx / w;
      col = idx % w;
      hit = (r >= r0) && (r < r0 + k) && (col >= c0) && (col < c0 + k) &&
            (anti ? (r - r0 == k - 1 - (col - c0)) : (r - r0 == col - c0));
      case (mode)
        0:       p = $urandom_range(0, 1);
        1:       p = hit ^ ($urandom_range(0, 9) == 0);
        default: p = hit;
      endcase
      send_beat(p, !partial && (idx == total - 1), 1'b0, '0);
    end
    if (!partial) images_sent++;
  endtask

  always @(posedge clk) begin : result_monitor
    side_t want;
    bit    moved;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_sides.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_longest_diagonal, '0);
      end else begin
        want = expected_sides.pop_front();
        if (out_longest_diagonal !== want)
          report_mismatch("wrong square side", out_longest_diagonal, want);
      end
    end
    moved        = rst_n && ((in_push && !in_full) || (out_pop && !out_empty));
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    out_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** isolated_diagonal_square_finder: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    logic [ids_pkg::CFG_W-1:0] phase_widths [PHASES];
    int                        phase_beats;
    int                        phase_images;
    phase_widths = '{12'd1, 12'd5, 12'd2048, 12'd3, 12'd4095, 12'd7, 12'd0, 12'd2};
    directed_steps = '{
      '{STEP_PIXEL, 1'b0, 1'b1, 12'd0,    1'b1, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b1, 12'd0,    1'b1, 12'd1},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd2,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b1, 12'd0,    1'b1, 12'd2},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b1, 12'd0,    1'b0, 12'd0},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd4095, 1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b1, 12'd0,    1'b0, 12'd0},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd4,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd3,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b1, 12'd0,    1'b0, 12'd0},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd4,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_WIDTH, 1'b0, 1'b0, 12'd2,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b0, 1'b0, 12'd0,    1'b0, 12'd0},
      '{STEP_PIXEL, 1'b1, 1'b1, 12'd0,    1'b0, 12'd0}
    };
    mismatches    = 0;
    beats_sent    = 0;
    images_sent   = 0;
    quiet_cycles  = 0;
    width_reg     = ids_pkg::COLUMNS_RESET;
    clear_image_state();
    set_idle_mode(IDLE_NONE);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_STEPS; i++) begin
      if (directed_steps[i].kind == STEP_WIDTH) begin
        settle();
        write_width(directed_steps[i].width);
      end else begin
        send_beat(directed_steps[i].pixel, directed_steps[i].eoi,
                  directed_steps[i].typed, directed_steps[i].side);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_width(phase_widths[ph]);
      set_idle_mode(idle_mode_t'(ph % 4));
      phase_beats  = beats_sent;
      phase_images = images_sent;
      while (beats_sent - phase_beats < PHASE_BEATS ||
             images_sent - phase_images < PHASE_IMAGES)
        send_image(1'b0);
      // sometimes leave an image open so the next width lands mid-image
      if (ph < PHASES - 1 && $urandom_range(0, 1)) send_image(1'b1);
    end

    settle();
    if (mismatches == 0) begin
      $display("** isolated_diagonal_square_finder: PASSED **");
    end else begin
      $display("** isolated_diagonal_square_finder: FAILED **");
    end
    $finish;
  end

endmodule
